@@ rtl/core/sasb_pkg.sv @@
// Shared types, constants and helpers for the sprite sort and batch unit.
`default_nettype none
package sasb_pkg;
   localparam int MaxEntries   = 32;
   localparam int VertsPerQuad = 6;
   localparam int TexW         = 32;
   localparam int DepthW       = 32;
   localparam int IdxW         = 5;
   localparam int VtxW         = 8;

   // input word codes
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_END  = 1'b1
   } opcode_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PLACE = 2'd0,
      KIND_BATCH = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   // sort modes
   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_BACK    = 2'd1,
      MODE_FRONT   = 2'd2,
      MODE_TEXTURE = 2'd3
   } mode_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      ST_IDLE, ST_RDCUR, ST_GETCUR, ST_CMP, ST_PUT,
      ST_PRD, ST_PEMIT, ST_BRD, ST_BACT, ST_BFIN
   } back_state_type;

   // one word in the front queue
   typedef struct packed {
      opcode_type               op;
      logic [TexW-1:0]          tex;
      logic signed [DepthW-1:0] depth;
   } queue_word_type;

   // one stored sprite record
   typedef struct packed {
      logic [TexW-1:0]          tex;
      logic signed [DepthW-1:0] depth;
      logic [IdxW-1:0]          idx;
   } record_type;

   // position to vertex number, kept to the output width
   function automatic logic [VtxW-1:0] to_vtx(input logic [VtxW-1:0] pos);
      to_vtx = pos * VtxW'(VertsPerQuad);
   endfunction

   // true when record a must be placed strictly before record b
   function automatic logic goes_before(input mode_type mode, input record_type a,
                                        input record_type b);
      case (mode)
         MODE_BACK:    goes_before = a.depth > b.depth;
         MODE_FRONT:   goes_before = a.depth < b.depth;
         MODE_TEXTURE: goes_before = a.tex < b.tex;
         default:      goes_before = 1'b0;
      endcase
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/sasb_front.sv @@
// Front end: accepts request words into a two-entry queue for the back end.
`default_nettype none
module sasb_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_opcode,
   input  wire logic [sasb_pkg::TexW-1:0]      req_texture_id,
   input  wire logic signed [sasb_pkg::DepthW-1:0] req_depth_key,
   output logic                                q_valid,
   input  wire logic                           q_pop,
   output sasb_pkg::queue_word_type            q_word
);
   sasb_pkg::queue_word_type entry_ff [2];
   sasb_pkg::queue_word_type wr_word;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   // classify the incoming word
   always_comb begin
      wr_word.op    = sasb_pkg::opcode_type'(req_opcode);
      wr_word.tex   = req_texture_id;
      wr_word.depth = req_depth_key;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = entry_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = q_pop & q_valid;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_word;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/sasb_back.sv @@
// Back end: record store, in-place insertion sort, placement and batch emission.
`default_nettype none
module sasb_back #(
   parameter int MAX_ENTRIES = sasb_pkg::MaxEntries
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [1:0]                 sort_mode,
   input  wire logic                       q_valid,
   output logic                            q_pop,
   input  wire sasb_pkg::queue_word_type   q_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [sasb_pkg::IdxW-1:0]       rsp_entry_index,
   output logic [sasb_pkg::VtxW-1:0]       rsp_vertex_offset,
   output logic [sasb_pkg::VtxW-1:0]       rsp_vertex_count,
   output logic [sasb_pkg::TexW-1:0]       rsp_batch_texture,
   output logic                            rsp_dropped,
   output logic                            rsp_last
);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int VW = sasb_pkg::VtxW;

   sasb_pkg::record_type store [MAX_ENTRIES];

   sasb_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [CW-1:0]         i_ff, i_in, j_ff, j_in;
   logic [CW-1:0]         run_start_ff, run_start_in;
   logic [sasb_pkg::TexW-1:0] run_tex_ff, run_tex_in;
   sasb_pkg::record_type  cur_ff, cur_in;
   sasb_pkg::record_type  rd_data_ff;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   sasb_pkg::record_type  wr_data;

   logic                  out_free, out_ld;
   sasb_pkg::kind_type    out_kind;
   logic [sasb_pkg::IdxW-1:0] out_idx;
   logic [VW-1:0]         out_off, out_cnt;
   logic [sasb_pkg::TexW-1:0] out_tex;
   logic                  out_last;

   logic                  rsp_valid_ff;
   logic [1:0]            kind_ff;
   logic [sasb_pkg::IdxW-1:0] idx_ff;
   logic [VW-1:0]         off_ff, cnt_ff;
   logic [sasb_pkg::TexW-1:0] tex_ff;
   logic                  dropped_ff, last_ff;

   logic [CW-1:0]         i_next;
   logic                  cur_first;
   sasb_pkg::mode_type    mode;

   assign mode      = sasb_pkg::mode_type'(sort_mode);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign i_next    = i_ff + CW'(1);
   assign cur_first = sasb_pkg::goes_before(mode, cur_ff, rd_data_ff);

   // record store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      run_start_in = run_start_ff;
      run_tex_in   = run_tex_ff;
      cur_in       = cur_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      out_ld       = 1'b0;
      out_kind     = sasb_pkg::KIND_PLACE;
      out_idx      = '0;
      out_off      = '0;
      out_cnt      = '0;
      out_tex      = '0;
      out_last     = 1'b0;

      case (state_ff)
         sasb_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_word.op == sasb_pkg::OP_LOAD) begin
                  q_pop = 1'b1;
                  if (count_ff >= CW'(MAX_ENTRIES)) begin
                     drop_in = 1'b1;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[AW-1:0];
                     wr_data.tex   = q_word.tex;
                     wr_data.depth = q_word.depth;
                     wr_data.idx   = sasb_pkg::IdxW'(count_ff);
                     count_in      = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  if (out_free) begin
                     q_pop    = 1'b1;
                     out_ld   = 1'b1;
                     out_kind = sasb_pkg::KIND_EMPTY;
                     out_last = 1'b1;
                     drop_in  = 1'b0;
                  end
               end else begin
                  q_pop = 1'b1;
                  if (count_ff == CW'(1) || mode == sasb_pkg::MODE_NONE) begin
                     i_in     = '0;
                     state_in = sasb_pkg::ST_PRD;
                  end else begin
                     i_in     = CW'(1);
                     state_in = sasb_pkg::ST_RDCUR;
                  end
               end
            end
         end
         // fetch the element to insert
         sasb_pkg::ST_RDCUR: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff[AW-1:0];
            state_in = sasb_pkg::ST_GETCUR;
         end
         sasb_pkg::ST_GETCUR: begin
            cur_in   = rd_data_ff;
            j_in     = i_ff;
            rd_en    = 1'b1;
            rd_addr  = AW'(i_ff - CW'(1));
            state_in = sasb_pkg::ST_CMP;
         end
         // shift neighbors that the element goes before up one slot
         sasb_pkg::ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            if (cur_first) begin
               wr_data = rd_data_ff;
               j_in    = j_ff - CW'(1);
               if (j_ff == CW'(1)) begin
                  state_in = sasb_pkg::ST_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(j_ff - CW'(2));
               end
            end else begin
               wr_data = cur_ff;
               if (i_next == count_ff) begin
                  i_in     = '0;
                  state_in = sasb_pkg::ST_PRD;
               end else begin
                  i_in     = i_next;
                  state_in = sasb_pkg::ST_RDCUR;
               end
            end
         end
         sasb_pkg::ST_PUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = cur_ff;
            if (i_next == count_ff) begin
               i_in     = '0;
               state_in = sasb_pkg::ST_PRD;
            end else begin
               i_in     = i_next;
               state_in = sasb_pkg::ST_RDCUR;
            end
         end
         // placement pass
         sasb_pkg::ST_PRD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff[AW-1:0];
            state_in = sasb_pkg::ST_PEMIT;
         end
         sasb_pkg::ST_PEMIT: begin
            if (out_free) begin
               out_ld   = 1'b1;
               out_kind = sasb_pkg::KIND_PLACE;
               out_idx  = rd_data_ff.idx;
               out_off  = sasb_pkg::to_vtx(VW'(i_ff));
               out_tex  = rd_data_ff.tex;
               if (i_next == count_ff) begin
                  i_in     = '0;
                  state_in = sasb_pkg::ST_BRD;
               end else begin
                  i_in     = i_next;
                  state_in = sasb_pkg::ST_PRD;
               end
            end
         end
         // batch pass: close a run whenever the texture changes
         sasb_pkg::ST_BRD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff[AW-1:0];
            state_in = sasb_pkg::ST_BACT;
         end
         sasb_pkg::ST_BACT: begin
            if (i_ff == '0 || rd_data_ff.tex == run_tex_ff || out_free) begin
               if (i_ff == '0) begin
                  run_start_in = '0;
                  run_tex_in   = rd_data_ff.tex;
               end else if (rd_data_ff.tex != run_tex_ff) begin
                  out_ld       = 1'b1;
                  out_kind     = sasb_pkg::KIND_BATCH;
                  out_off      = sasb_pkg::to_vtx(VW'(run_start_ff));
                  out_cnt      = sasb_pkg::to_vtx(VW'(i_ff - run_start_ff));
                  out_tex      = run_tex_ff;
                  run_start_in = i_ff;
                  run_tex_in   = rd_data_ff.tex;
               end
               i_in     = i_next;
               state_in = (i_next == count_ff) ? sasb_pkg::ST_BFIN : sasb_pkg::ST_BRD;
            end
         end
         sasb_pkg::ST_BFIN: begin
            if (out_free) begin
               out_ld   = 1'b1;
               out_kind = sasb_pkg::KIND_BATCH;
               out_off  = sasb_pkg::to_vtx(VW'(run_start_ff));
               out_cnt  = sasb_pkg::to_vtx(VW'(count_ff - run_start_ff));
               out_tex  = run_tex_ff;
               out_last = 1'b1;
               count_in = '0;
               drop_in  = 1'b0;
               state_in = sasb_pkg::ST_IDLE;
            end
         end
         default: state_in = sasb_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sasb_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      run_start_ff <= run_start_in;
      run_tex_ff   <= run_tex_in;
      cur_ff       <= cur_in;
      if (out_ld) begin
         kind_ff    <= out_kind;
         idx_ff     <= out_idx;
         off_ff     <= out_off;
         cnt_ff     <= out_cnt;
         tex_ff     <= out_tex;
         dropped_ff <= drop_ff;
         last_ff    <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_entry_index   = idx_ff;
   assign rsp_vertex_offset = off_ff;
   assign rsp_vertex_count  = cnt_ff;
   assign rsp_batch_texture = tex_ff;
   assign rsp_dropped       = dropped_ff;
   assign rsp_last          = last_ff;
endmodule
`default_nettype wire

@@ rtl/core/sprite_sort_and_batch_unit.sv @@
// Top level of the sprite sort and batch unit.
// Load words go through a two-word queue and, up to MAX_ENTRIES, are written
// into the record store at one per cycle while the back end is idle. An end
// word orders the stored entries stably by csr sort mode with an in-place
// insertion sort over a record store with one write and one read port. It
// then emits one placement word per entry and one batch word at the close of
// each texture run; an empty end gives one marker word.
`default_nettype none
module sprite_sort_and_batch_unit #(
   parameter int MAX_ENTRIES = sasb_pkg::MaxEntries
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic [sasb_pkg::TexW-1:0]          req_texture_id,
   input  wire logic signed [sasb_pkg::DepthW-1:0] req_depth_key,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_kind,
   output logic [sasb_pkg::IdxW-1:0]               rsp_entry_index,
   output logic [sasb_pkg::VtxW-1:0]               rsp_vertex_offset,
   output logic [sasb_pkg::VtxW-1:0]               rsp_vertex_count,
   output logic [sasb_pkg::TexW-1:0]               rsp_batch_texture,
   output logic                                    rsp_dropped,
   output logic                                    rsp_last,
   input  wire logic                               csr_wr_en,
   input  wire logic [1:0]                         csr_wr_data
);
   logic                      q_valid, q_pop;
   sasb_pkg::queue_word_type  q_word;
   logic [1:0]                sort_mode_ff;

   // sort mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_mode_ff <= sasb_pkg::MODE_TEXTURE;
      end else if (csr_wr_en) begin
         sort_mode_ff <= csr_wr_data;
      end
   end

   sasb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_texture_id (req_texture_id),
      .req_depth_key  (req_depth_key),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_word         (q_word)
   );

   sasb_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .sort_mode         (sort_mode_ff),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_word            (q_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_vertex_offset (rsp_vertex_offset),
      .rsp_vertex_count  (rsp_vertex_count),
      .rsp_batch_texture (rsp_batch_texture),
      .rsp_dropped       (rsp_dropped),
      .rsp_last          (rsp_last)
   );
endmodule
`default_nettype wire

@@ dv/sprite_sort_and_batch_unit_test.sv @@
// Self-checking testbench for the sprite sort and batch unit.
`timescale 1ns / 1ps
`default_nettype none
module sprite_sort_and_batch_unit_test;
   import sasb_pkg::*;

   // one expected result word
   typedef struct {
      kind_type         kind;
      logic [IdxW-1:0]  idx;
      logic [VtxW-1:0]  offset;
      logic [VtxW-1:0]  count;
      logic [TexW-1:0]  tex;
      logic             dropped;
      logic             last;
   } batch_word_type;

   // predicts the result words of each end word and checks them in order
   class batch_scoreboard;
      logic [TexW-1:0]          tex_mem[MaxEntries];
      logic signed [DepthW-1:0] depth_mem[MaxEntries];
      int                       n_loaded;
      logic                     drop_seen;
      mode_type                 mode;
      batch_word_type           pending[$];
      int                       errors;
      int                       checked;

      function void clear_state();
         n_loaded  = 0;
         drop_seen = 1'b0;
         mode      = MODE_TEXTURE;
      endfunction

      // strict ordering under the current mode
      function bit ahead_of(int a, int b);
         case (mode)
            MODE_BACK:    return depth_mem[a] > depth_mem[b];
            MODE_FRONT:   return depth_mem[a] < depth_mem[b];
            MODE_TEXTURE: return tex_mem[a] < tex_mem[b];
            default:      return 1'b0;
         endcase
      endfunction

      function void note_word(logic op, logic [TexW-1:0] tex, logic [DepthW-1:0] depth);
         int             ord[MaxEntries];
         int             j;
         int             cur;
         int             run_start;
         batch_word_type w;
         if (op == OP_LOAD) begin
            if (n_loaded >= MaxEntries) drop_seen = 1'b1;
            else begin
               tex_mem[n_loaded]   = tex;
               depth_mem[n_loaded] = depth;
               n_loaded++;
            end
            return;
         end
         w.dropped = drop_seen;
         if (n_loaded == 0) begin
            w.kind = KIND_EMPTY; w.idx = '0; w.offset = '0; w.count = '0;
            w.tex = '0; w.last = 1'b1;
            pending.push_back(w);
         end else begin
            // stable insertion sort
            for (int i = 0; i < n_loaded; i++) begin
               cur = i;
               j = i;
               while (j > 0 && ahead_of(cur, ord[j-1])) begin
                  ord[j] = ord[j-1];
                  j--;
               end
               ord[j] = cur;
            end
            for (int i = 0; i < n_loaded; i++) begin
               w.kind = KIND_PLACE; w.idx = IdxW'(ord[i]);
               w.offset = VtxW'(i * VertsPerQuad);
               w.count = '0; w.tex = tex_mem[ord[i]]; w.last = 1'b0;
               pending.push_back(w);
            end
            run_start = 0;
            for (int i = 1; i <= n_loaded; i++) begin
               if (i == n_loaded || tex_mem[ord[i]] != tex_mem[ord[i-1]]) begin
                  w.kind = KIND_BATCH; w.idx = '0;
                  w.offset = VtxW'(run_start * VertsPerQuad);
                  w.count = VtxW'((i - run_start) * VertsPerQuad);
                  w.tex = tex_mem[ord[run_start]]; w.last = (i == n_loaded);
                  pending.push_back(w);
                  run_start = i;
               end
            end
         end
         n_loaded  = 0;
         drop_seen = 1'b0;
      endfunction

      function void check_word(batch_word_type got);
         batch_word_type exp;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word kind=%0d, expected none", $time, got.kind);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.kind !== exp.kind || got.idx !== exp.idx || got.offset !== exp.offset ||
             got.count !== exp.count || got.tex !== exp.tex ||
             got.dropped !== exp.dropped || got.last !== exp.last) begin
            $display("%0t: mismatch exp k=%0d i=%0d o=%0d c=%0d t=%h d=%0d l=%0d",
                     $time, exp.kind, exp.idx, exp.offset, exp.count, exp.tex,
                     exp.dropped, exp.last);
            $display("%0t:          got k=%0d i=%0d o=%0d c=%0d t=%h d=%0d l=%0d",
                     $time, got.kind, got.idx, got.offset, got.count, got.tex,
                     got.dropped, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_opcode;
   logic [TexW-1:0]          req_texture_id;
   logic signed [DepthW-1:0] req_depth_key;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_kind;
   logic [IdxW-1:0]          rsp_entry_index;
   logic [VtxW-1:0]          rsp_vertex_offset;
   logic [VtxW-1:0]          rsp_vertex_count;
   logic [TexW-1:0]          rsp_batch_texture;
   logic                     rsp_dropped;
   logic                     rsp_last;
   logic                     csr_wr_en;
   logic [1:0]               csr_wr_data;

   batch_scoreboard sb;
   int  cycle_count;
   bit  idle_allowed;
   bit  hold_rsp;
   int  words_sent;
   int  ends_sent;

   sprite_sort_and_batch_unit uut (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_texture_id,
      .req_depth_key, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_entry_index,
      .rsp_vertex_offset, .rsp_vertex_count, .rsp_batch_texture, .rsp_dropped,
      .rsp_last, .csr_wr_en, .csr_wr_data
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      batch_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind = kind_type'(rsp_kind); got.idx = rsp_entry_index;
         got.offset = rsp_vertex_offset; got.count = rsp_vertex_count;
         got.tex = rsp_batch_texture; got.dropped = rsp_dropped; got.last = rsp_last;
         sb.check_word(got);
      end
   end

   // receiver: random stall bursts, or a long hold-off on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            // long enough to outlast a full load and a worst-case sort
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_allowed && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic op, logic [TexW-1:0] tex, logic [DepthW-1:0] depth);
      int n;
      if (idle_allowed && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_texture_id <= tex;
      req_depth_key  <= depth;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(op, tex, depth);
      words_sent++;
      if (op == OP_END) ends_sent++;
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   // mode change only while idle
   task automatic set_mode(mode_type m);
      pause_sender();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.mode = m;
   endtask

   // few texture values so runs form; depths with repeats for tie checks
   function automatic logic [TexW-1:0] pick_tex();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFC + $urandom_range(0, 3);
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DepthW-1:0] pick_depth();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 2) << 16;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_batch(int n);
      for (int i = 0; i < n; i++) send_word(OP_LOAD, pick_tex(), pick_depth());
      send_word(OP_END, $urandom, $urandom);
   endtask

   initial begin
      int n;
      sb = new();
      sb.clear_state();
      sb.errors = 0; sb.checked = 0;
      cycle_count = 0; words_sent = 0; ends_sent = 0;
      idle_allowed = 1'b0; hold_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OP_LOAD; req_texture_id = '0; req_depth_key = '0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty end, reset mode with ties and extremes
      send_word(OP_END, '1, '1);
      send_word(OP_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_word(OP_LOAD, 32'h0, 32'h8000_0000);
      send_word(OP_LOAD, 32'hFFFF_FFFF, 32'h0);
      send_word(OP_LOAD, 32'h0, 32'hFFFF_FFFF);
      send_word(OP_END, '0, '0);
      // overflow: fill past capacity to raise the drop flag
      for (int i = 0; i < MaxEntries + 2; i++)
         send_word(OP_LOAD, i % 3, 32'h0001_0000 * i);
      send_word(OP_END, '0, '0);
      send_word(OP_END, '0, '0);

      // random batches through every mode
      idle_allowed = 1'b1;
      for (int m = 0; m < 4; m++) begin
         set_mode(mode_type'(m));
         for (int b = 0; b < 3; b++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
            send_batch(n);
         end
      end

      // long receiver hold-off while the sender keeps offering
      set_mode(MODE_BACK);
      hold_rsp = 1'b1;
      send_batch(MaxEntries);
      send_batch(3);
      pause_sender();

      // closing part without idling
      idle_allowed = 1'b0;
      set_mode(MODE_FRONT);
      send_batch(5);
      set_mode(MODE_NONE);
      send_batch(4);
      set_mode(MODE_TEXTURE);
      send_batch(6);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d words in %0d batches over all sort modes, checked %0d results",
               words_sent, ends_sent, sb.checked);
      $display("covered empty ends, overflow drops, ties, stalls and a long output hold-off");
      if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
